// ----- hdl/rlelg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlelg_pkg
// Shared constants and types for the run-length encoder with literal groups.
// ----------------------------------------------------------------------------
package rlelg_pkg;

    localparam int MAX_RUN = 32;                    // longest run and literal group
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);   // holds 0 .. MAX_RUN
    localparam int ADDR_W  = $clog2(MAX_RUN);       // literal store address

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOSE,
        S_HDR,
        S_DATA,
        S_CNT,
        S_VAL,
        S_NEXT
    } t_state;

    // pass through the close sequence for one word
    typedef enum logic [1:0] {
        PH_RUN,     // close the open run on a new byte
        PH_LAST,    // close the run left open by the final byte
        PH_FLUSH    // flush the remaining literal group
    } t_phase;

endpackage

// ----- hdl/rlelg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlelg_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rlelg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/run_length_encoder_literal_groups.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_encoder_literal_groups
// Byte stream run-length encoder: runs go out as count and byte, single bytes
// are gathered in a literal store and go out as header and bytes.
// ----------------------------------------------------------------------------
// Sequence: a word is taken in IDLE and passes CLOSE; any results then go out
//   from HDR and DATA (literal group) and CNT and VAL (run), and the word ends in
//   NEXT. A final byte adds a closing pass through CLOSE and NEXT, and a flush of
//   a short literal group; output stalls hold the sequence. The sequencer holds
//   one word at a time.
// Reset: synchronous, active low; clears the open run and the literal count,
//   the literal store is not cleared.
// ----------------------------------------------------------------------------
module run_length_encoder_literal_groups
    import rlelg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_byte i_data_byte,
    input  logic  i_last_byte,
    output logic  o_valid,
    input  logic  i_stall,
    output t_byte o_out_byte,
    output logic  o_is_header,
    output logic  o_burst_end
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_byte  r_in_byte, n_in_byte;
    logic   r_last, n_last;
    t_byte  r_rv, n_rv;
    t_cnt   r_rc, n_rc;
    t_cnt   r_lc, n_lc;
    t_addr  r_k, n_k;
    logic   r_run_after, n_run_after;
    logic   r_out_valid, n_out_valid;
    t_byte  r_out_byte, n_out_byte;
    logic   r_is_header, n_is_header;
    logic   r_burst_end, n_burst_end;

    logic   w_free;
    logic   w_extend;
    logic   w_close;
    logic   w_k_last;
    logic   w_final;
    logic   w_we;
    t_addr  w_raddr;
    t_byte  w_rdata;

    rlelg_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_RUN)
    ) u_lit_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_lc[ADDR_W-1:0]),
        .i_wdata (r_rv),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_free   = !r_out_valid || !i_stall;
    assign w_extend = (r_rc != '0) && (r_in_byte == r_rv) && (r_rc < CNT_W'(MAX_RUN));
    assign w_close  = (r_phase != PH_RUN) || ((r_rc != '0) && !w_extend);
    assign w_k_last = (CNT_W'(r_k) + CNT_W'(1)) == r_lc;
    // nothing follows in this word once past the first close, or if not last
    assign w_final  = (r_phase != PH_RUN) || !r_last;
    assign w_we     = (r_state == S_CLOSE) && w_close && (r_rc == CNT_W'(1));
    // look ahead one entry when a literal leaves, so the next is ready
    assign w_raddr  = (r_state == S_DATA && w_free) ? ADDR_W'(r_k + ADDR_W'(1)) : r_k;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (!w_close) begin
                    n_state = S_NEXT;
                end else if (r_rc == CNT_W'(1)) begin
                    n_state = ((r_lc + CNT_W'(1)) == CNT_W'(MAX_RUN)) ? S_HDR : S_NEXT;
                end else begin
                    n_state = (r_lc != '0) ? S_HDR : S_CNT;
                end
            end
            S_HDR: begin
                if (w_free) begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (w_free && w_k_last) begin
                    n_state = r_run_after ? S_CNT : S_NEXT;
                end
            end
            S_CNT: begin
                if (w_free) begin
                    n_state = S_VAL;
                end
            end
            S_VAL: begin
                if (w_free) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                case (r_phase)
                    PH_RUN:   n_state = r_last ? S_CLOSE : S_IDLE;
                    PH_LAST:  n_state = (r_lc != '0) ? S_HDR : S_IDLE;
                    default:  n_state = S_IDLE;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase     = r_phase;
        n_in_byte   = r_in_byte;
        n_last      = r_last;
        n_rv        = r_rv;
        n_rc        = r_rc;
        n_lc        = r_lc;
        n_k         = r_k;
        n_run_after = r_run_after;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_is_header = r_is_header;
        n_burst_end = r_burst_end;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in_byte = i_data_byte;
                    n_last    = i_last_byte;
                    n_phase   = PH_RUN;
                end
            end
            S_CLOSE: begin
                n_k = '0;
                if (w_close) begin
                    if (r_rc == CNT_W'(1)) begin
                        // single byte joins the literal group
                        n_lc        = r_lc + CNT_W'(1);
                        n_run_after = 1'b0;
                    end else begin
                        n_run_after = 1'b1;
                    end
                end
            end
            S_HDR: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = (r_lc == CNT_W'(1)) ? BYTE_W'(1)
                                                      : BYTE_W'(9'd256 - 9'(r_lc));
                    n_is_header = 1'b1;
                    n_burst_end = 1'b0;
                end
            end
            S_DATA: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_rdata;
                    n_is_header = 1'b0;
                    n_burst_end = w_k_last && !r_run_after && w_final;
                    n_k         = ADDR_W'(r_k + ADDR_W'(1));
                    if (w_k_last) begin
                        n_lc = '0;
                    end
                end
            end
            S_CNT: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = BYTE_W'(r_rc);
                    n_is_header = 1'b1;
                    n_burst_end = 1'b0;
                end
            end
            S_VAL: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_rv;
                    n_is_header = 1'b0;
                    n_burst_end = w_final;
                end
            end
            S_NEXT: begin
                n_k = '0;
                case (r_phase)
                    PH_RUN: begin
                        if (w_extend) begin
                            n_rc = r_rc + CNT_W'(1);
                        end else begin
                            n_rv = r_in_byte;
                            n_rc = CNT_W'(1);
                        end
                        if (r_last) begin
                            n_phase = PH_LAST;
                        end
                    end
                    PH_LAST: begin
                        n_rc = '0;
                        if (r_lc != '0) begin
                            n_phase = PH_FLUSH;
                        end
                    end
                    default: begin
                        n_rc = '0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_RUN;
            r_rv        <= '0;
            r_rc        <= '0;
            r_lc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_rv        <= n_rv;
            r_rc        <= n_rc;
            r_lc        <= n_lc;
            r_out_valid <= n_out_valid;
        end
        r_in_byte   <= n_in_byte;
        r_last      <= n_last;
        r_k         <= n_k;
        r_run_after <= n_run_after;
        r_out_byte  <= n_out_byte;
        r_is_header <= n_is_header;
        r_burst_end <= n_burst_end;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_header = r_is_header;
    assign o_burst_end = r_burst_end;

    // a full literal group never survives to the next word
    a_lc_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_lc < CNT_W'(MAX_RUN)))
        else $error("literal group left full between words");

    // a run never grows past its cap
    a_rc_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rc <= CNT_W'(MAX_RUN))
        else $error("run count beyond cap");

    // leaving the literal read-out always empties the group
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state) == S_DATA && r_state != S_DATA) |-> (r_lc == '0))
        else $error("literal group not emptied by flush");

    // after a final byte the block goes idle with no run open
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state) == S_NEXT && $past(r_phase) != PH_RUN
            && r_state == S_IDLE) |-> (r_rc == '0 && r_lc == '0))
        else $error("stream end left state open");

endmodule
